### sv/qtba_pkg.sv
`default_nettype none
package qtba_pkg;

  // Per-node code held in the node memory.
  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0,
    ST_FREE   = 2'd1,
    ST_TAKEN  = 2'd2,
    ST_SPLIT  = 2'd3
  } node_st_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_NO_SPACE  = 2'd2,
    STAT_BAD_HANDLE = 2'd3
  } status_t;

  // Item kinds carried on tuser.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Configuration register index.
  localparam logic REG_SPACE_SIZE = 1'b0;

  localparam int SIZE_W  = 12;
  localparam int FIDX_W  = 15;
  localparam int SPACE_W = 3;
  localparam int PLACE_W = 11;
  localparam logic [SIZE_W-1:0] SPACE_SIZE_RST = 12'd2048;

endpackage
`default_nettype wire

### sv/qtba_node_mem.sv
`default_nettype none
module qtba_node_mem
  import qtba_pkg::*;
#(
  parameter int DEPTH = 43688,
  parameter int AW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire node_st_t      wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output node_st_t           rdata
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = node_st_t'(rdata_r);

endmodule
`default_nettype wire

### sv/qtba_place.sv
`default_nettype none
module qtba_place
  import qtba_pkg::*;
#(
  parameter int LEVELS = 6,
  parameter int LW     = 3,
  parameter int IXW    = 15
) (
  input  wire logic [SIZE_W-1:0]  space_size,
  input  wire logic [LW-1:0]      lvl,
  input  wire logic [IXW-1:0]     idx,
  output logic      [SIZE_W-1:0]  block_size,
  output logic      [FIDX_W-1:0]  block_index,
  output logic      [SPACE_W-1:0] space,
  output logic      [PLACE_W-1:0] place_x,
  output logic      [PLACE_W-1:0] place_y
);

  logic [LEVELS-1:0]        x_w;
  logic [LEVELS-1:0]        y_w;
  logic [IXW-1:0]           top_w;
  logic [LEVELS+SIZE_W-1:0] px_w;
  logic [LEVELS+SIZE_W-1:0] py_w;

  // Odd index bits give x, even bits give y, below the block's level.
  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      x_w[k] = (k < int'(lvl)) ? idx[2*k+1] : 1'b0;
      y_w[k] = (k < int'(lvl)) ? idx[2*k] : 1'b0;
    end
  end

  assign block_size  = space_size >> lvl;
  assign block_index = FIDX_W'(idx);
  assign top_w       = idx >> {lvl, 1'b0};
  assign space       = top_w[SPACE_W-1:0];
  assign px_w        = (LEVELS+SIZE_W)'(x_w) * (LEVELS+SIZE_W)'(block_size);
  assign py_w        = (LEVELS+SIZE_W)'(y_w) * (LEVELS+SIZE_W)'(block_size);
  assign place_x     = px_w[PLACE_W-1:0];
  assign place_y     = py_w[PLACE_W-1:0];

endmodule
`default_nettype wire

### sv/quadtree_buddy_allocator.sv
// Allocate: each node on the next-fit walk is read and then judged; the walk climbs
// past last children to the next sibling, and a split writes four free children.
// Free: levels of another size are skipped, matching levels are read and checked, and
// each merged level reads and clears four siblings and frees the parent; merging stops
// at a sibling that is not free or at a whole space. One item at a time.
// Reset is synchronous; a clearing pass then writes every node entry, one per cycle
// (SPACES*(4^(LEVELS+1)-1)/3 entries, 43688 by default).
`default_nettype none
module quadtree_buddy_allocator
  import qtba_pkg::*;
#(
  parameter int SPACES = 8,
  parameter int LEVELS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // request_width, request_height, free_block_size, free_block_index, zero fill
  input  wire logic [55:0] in_tdata,
  // kind
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status, block_size, block_index, space, place_x, place_y,
  // space_opened, space_released
  output logic [55:0]      out_tdata
);

  localparam int NODE_COUNT = SPACES * ((4**(LEVELS+1) - 1) / 3);
  localparam int AW  = $clog2(NODE_COUNT);
  localparam int LW  = $clog2(LEVELS + 2);
  localparam int IW  = $clog2(SPACES) + 2*LEVELS;
  localparam int IXW = (IW > FIDX_W) ? IW : FIDX_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, A_RD, A_EV, A_SPLIT, A_UP,
    F_SCAN, F_CHK, M_RD, M_EV, M_CLR, M_PAR, S_DONE
  } state_t;

  state_t           state_r;
  logic [AW-1:0]    clr_r;
  logic [SIZE_W-1:0] ss_r;
  logic [LW-1:0]    cur_l_r;
  logic [IW-1:0]    cur_i_r;
  logic [LW-1:0]    cl_r, sl_r, lvl_r;
  logic [IW-1:0]    ci_r, si_r;
  logic [SIZE_W-1:0] req_r, fsz_r;
  logic [IXW-1:0]   fidx_r;
  logic [1:0]       k_r;
  logic             from_next_r, opened_r;
  status_t          res_stat_r;
  logic [LW-1:0]    res_l_r;
  logic [IXW-1:0]   res_i_r;
  logic             res_open_r, res_rel_r;
  logic             out_valid_r;
  logic [55:0]      out_data_r;

  logic [AW-1:0]    base_tab [LEVELS+2];
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  node_st_t         mem_wdata, st;

  // Level base addresses inside the node memory.
  for (genvar g = 0; g < LEVELS + 2; g++) begin : g_base
    assign base_tab[g] = AW'(SPACES * ((4**g - 1) / 3));
  end

  // Configuration port.
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_SPACE_SIZE) ? {20'd0, ss_r} : 32'd0;

  // Walk decisions for the node just read.
  logic [SIZE_W-1:0] edge_w, half_w, w_in, h_in, req_in;
  logic              descend_w, wrapped_w, take_w, split_w, at_deep;
  logic [IW-1:0]     child_w;
  logic [IXW-1:0]    fpar_w, fsib_w, ftop_w;
  logic              fmatch_w;

  assign at_deep   = (cl_r == LW'(LEVELS));
  assign edge_w    = ss_r >> cl_r;
  assign half_w    = edge_w >> 1;
  assign descend_w = from_next_r && !at_deep && (st == ST_SPLIT);
  assign wrapped_w = from_next_r && (cl_r == sl_r) && (ci_r == si_r);
  assign take_w    = !descend_w && !wrapped_w && (st == ST_FREE) && (req_r <= edge_w)
                     && ((req_r > half_w) || at_deep);
  assign split_w   = !descend_w && !wrapped_w && !take_w && (st == ST_FREE)
                     && (req_r <= half_w) && !at_deep;
  assign child_w   = ci_r | IW'(k_r);
  assign fpar_w    = fidx_r >> 2;
  assign fsib_w    = {fpar_w[IXW-3:0], k_r};
  assign ftop_w    = fidx_r >> {lvl_r, 1'b0};
  assign fmatch_w  = ((ss_r >> lvl_r) == fsz_r) && (ftop_w < IXW'(SPACES));
  assign w_in      = in_tdata[11:0];
  assign h_in      = in_tdata[23:12];
  assign req_in    = (w_in > h_in) ? w_in : h_in;

  // Node memory port selection by state.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = ST_UNUSED;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = (clr_r < AW'(SPACES)) ? ST_FREE : ST_UNUSED;
      end
      A_RD: begin
        mem_re    = 1'b1;
        mem_raddr = base_tab[cl_r] + AW'(ci_r);
      end
      A_EV: begin
        mem_we    = take_w || split_w;
        mem_waddr = base_tab[cl_r] + AW'(ci_r);
        mem_wdata = take_w ? ST_TAKEN : ST_SPLIT;
      end
      A_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = base_tab[cl_r] + AW'(child_w);
        mem_wdata = ST_FREE;
      end
      F_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = base_tab[lvl_r] + AW'(fidx_r);
      end
      F_CHK: begin
        mem_we    = (st == ST_TAKEN);
        mem_waddr = base_tab[lvl_r] + AW'(fidx_r);
        mem_wdata = ST_FREE;
      end
      M_RD: begin
        mem_re    = 1'b1;
        mem_raddr = base_tab[lvl_r] + AW'(fsib_w);
      end
      M_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = base_tab[lvl_r] + AW'(fsib_w);
        mem_wdata = ST_UNUSED;
      end
      M_PAR: begin
        mem_we    = 1'b1;
        mem_waddr = base_tab[lvl_r - LW'(1)] + AW'(fpar_w);
        mem_wdata = ST_FREE;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  qtba_node_mem #(
    .DEPTH (NODE_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (st)
  );

  // Placement of the result block.
  logic [SIZE_W-1:0]  p_size;
  logic [FIDX_W-1:0]  p_index;
  logic [SPACE_W-1:0] p_space;
  logic [PLACE_W-1:0] p_x, p_y;

  qtba_place #(
    .LEVELS (LEVELS),
    .LW     (LW),
    .IXW    (IXW)
  ) u_place (
    .space_size  (ss_r),
    .lvl         (res_l_r),
    .idx         (res_i_r),
    .block_size  (p_size),
    .block_index (p_index),
    .space       (p_space),
    .place_x     (p_x),
    .place_y     (p_y)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer: walk, split, free and merge over the node memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ss_r        <= SPACE_SIZE_RST;
      cur_l_r     <= '0;
      cur_i_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && cfg_paddr[2] == REG_SPACE_SIZE) begin
        ss_r <= cfg_pwdata[SIZE_W-1:0];
      end
      // A taken beat empties the result register unless a new result loads it.
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(NODE_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            req_r       <= req_in;
            fsz_r       <= in_tdata[35:24];
            fidx_r      <= IXW'(in_tdata[50:36]);
            cl_r        <= cur_l_r;
            ci_r        <= cur_i_r;
            sl_r        <= cur_l_r;
            si_r        <= cur_i_r;
            from_next_r <= 1'b0;
            opened_r    <= 1'b0;
            lvl_r       <= '0;
            k_r         <= '0;
            if (in_tuser[0] == KIND_FREE) begin
              state_r <= F_SCAN;
            end else if (req_in > ss_r) begin
              res_stat_r <= STAT_TOO_LARGE;
              state_r    <= S_DONE;
            end else begin
              state_r <= A_RD;
            end
          end
        end
        A_RD: begin
          state_r <= A_EV;
        end
        A_EV: begin
          if (descend_w) begin
            cl_r    <= cl_r + LW'(1);
            ci_r    <= ci_r << 2;
            state_r <= A_RD;
          end else if (wrapped_w) begin
            cur_l_r    <= cl_r;
            cur_i_r    <= ci_r;
            res_stat_r <= STAT_NO_SPACE;
            state_r    <= S_DONE;
          end else if (take_w) begin
            cur_l_r    <= cl_r;
            cur_i_r    <= ci_r;
            res_stat_r <= STAT_OK;
            res_l_r    <= cl_r;
            res_i_r    <= IXW'(ci_r);
            res_open_r <= opened_r || (cl_r == '0);
            res_rel_r  <= 1'b0;
            state_r    <= S_DONE;
          end else if (split_w) begin
            if (cl_r == '0) begin
              opened_r <= 1'b1;
            end
            if (sl_r == cl_r && si_r == ci_r) begin
              sl_r <= cl_r + LW'(1);
              si_r <= ci_r << 2;
            end
            cl_r        <= cl_r + LW'(1);
            ci_r        <= ci_r << 2;
            k_r         <= '0;
            from_next_r <= 1'b0;
            state_r     <= A_SPLIT;
          end else begin
            state_r <= A_UP;
          end
        end
        A_SPLIT: begin
          k_r <= k_r + 2'd1;
          if (k_r == 2'd3) begin
            state_r <= A_RD;
          end
        end
        A_UP: begin
          // Climb past last children, then step to the next sibling.
          if (cl_r != '0 && ci_r[1:0] == 2'd3) begin
            cl_r <= cl_r - LW'(1);
            ci_r <= ci_r >> 2;
          end else begin
            if (cl_r == '0 && ci_r == IW'(SPACES - 1)) begin
              ci_r <= '0;
            end else begin
              ci_r <= ci_r + IW'(1);
            end
            from_next_r <= 1'b1;
            state_r     <= A_RD;
          end
        end
        F_SCAN: begin
          if (lvl_r > LW'(LEVELS)) begin
            res_stat_r <= STAT_BAD_HANDLE;
            state_r    <= S_DONE;
          end else if (fmatch_w) begin
            state_r <= F_CHK;
          end else begin
            lvl_r <= lvl_r + LW'(1);
          end
        end
        F_CHK: begin
          if (st == ST_TAKEN) begin
            k_r     <= '0;
            state_r <= M_RD;
          end else begin
            lvl_r   <= lvl_r + LW'(1);
            state_r <= F_SCAN;
          end
        end
        M_RD: begin
          if (lvl_r == '0) begin
            res_stat_r <= STAT_OK;
            res_l_r    <= lvl_r;
            res_i_r    <= fidx_r;
            res_open_r <= 1'b0;
            res_rel_r  <= 1'b1;
            state_r    <= S_DONE;
          end else begin
            state_r <= M_EV;
          end
        end
        M_EV: begin
          if (st != ST_FREE) begin
            res_stat_r <= STAT_OK;
            res_l_r    <= lvl_r;
            res_i_r    <= fidx_r;
            res_open_r <= 1'b0;
            res_rel_r  <= 1'b0;
            state_r    <= S_DONE;
          end else begin
            k_r <= k_r + 2'd1;
            if (k_r == 2'd3) begin
              state_r <= M_CLR;
            end else begin
              state_r <= M_RD;
            end
          end
        end
        M_CLR: begin
          k_r <= k_r + 2'd1;
          if (k_r == 2'd3) begin
            state_r <= M_PAR;
          end
        end
        M_PAR: begin
          // Four free siblings collapse into their parent.
          if (cur_l_r == lvl_r && IXW'(cur_i_r >> 2) == fpar_w) begin
            cur_l_r <= lvl_r - LW'(1);
            cur_i_r <= IW'(fpar_w);
          end
          lvl_r   <= lvl_r - LW'(1);
          fidx_r  <= fpar_w;
          k_r     <= '0;
          state_r <= M_RD;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            if (res_stat_r == STAT_OK) begin
              out_data_r <= {res_rel_r, res_open_r, p_y, p_x, p_space, p_index, p_size,
                             res_stat_r};
            end else begin
              out_data_r <= {54'd0, res_stat_r};
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### test/tb_quadtree_buddy_allocator.sv
`default_nettype none

// One expected or observed result beat, unpacked.
typedef struct {
  qtba_pkg::status_t status;
  logic [11:0] blk_size;
  logic [14:0] blk_index;
  logic [2:0]  space;
  logic [10:0] place_x;
  logic [10:0] place_y;
  logic        opened;
  logic        released;
} alloc_result_t;

// Mirrors the allocator tree and cursor, predicts each result and checks it.
class alloc_scoreboard;
  localparam int SP = 8;
  localparam int LV = 6;
  localparam int NODES = 43688;

  qtba_pkg::node_st_t nodes[NODES];
  int unsigned cur_l, cur_i, space_edge;
  alloc_result_t pending_q[$];
  int live_lvl[$];
  int live_idx[$];
  int mismatches, checked, n_ok, n_large, n_full, n_bad, n_opened, n_released;

  function new();
    foreach (nodes[k]) nodes[k] = qtba_pkg::ST_UNUSED;
    for (int s = 0; s < SP; s++) nodes[s] = qtba_pkg::ST_FREE;
    cur_l = 0;
    cur_i = 0;
    space_edge = 2048;
  endfunction

  function void set_space_size(int unsigned v);
    space_edge = v & 12'hFFF;
  endfunction

  function int unsigned lvl_first(int unsigned l);
    return SP * (((1 << (2 * l)) - 1) / 3);
  endfunction

  function qtba_pkg::node_st_t node_rd(int unsigned l, int unsigned i);
    if (l > LV || i >= (SP << (2 * l))) return qtba_pkg::ST_UNUSED;
    return nodes[lvl_first(l) + i];
  endfunction

  function void node_wr(int unsigned l, int unsigned i, qtba_pkg::node_st_t v);
    if (l > LV || i >= (SP << (2 * l))) return;
    nodes[lvl_first(l) + i] = v;
  endfunction

  // Next leaf in Morton order across all spaces, wrapping around.
  function void step_leaf(ref int unsigned l, ref int unsigned i);
    while (l > 0 && (i & 3) == 3) begin
      i = i >> 2;
      l--;
    end
    i++;
    if (l == 0 && i >= SP) i = 0;
    while (l < LV && node_rd(l, i) == qtba_pkg::ST_SPLIT) begin
      i = i << 2;
      l++;
    end
  endfunction

  // Fill in size, index, space and Morton-decoded placement of a block.
  function void place_block(ref alloc_result_t r, input int unsigned l, input int unsigned i);
    int unsigned edge_px, loc, x, y;
    edge_px = space_edge >> l;
    loc = i & ((1 << (2 * l)) - 1);
    x = 0;
    y = 0;
    for (int k = 0; k < l; k++) begin
      y |= ((loc >> (2 * k)) & 1) << k;
      x |= ((loc >> (2 * k + 1)) & 1) << k;
    end
    r.blk_size = 12'(edge_px);
    r.blk_index = 15'(i);
    r.space = 3'(i >> (2 * l));
    r.place_x = 11'(x * edge_px);
    r.place_y = 11'(y * edge_px);
  endfunction

  function alloc_result_t alloc_block(int unsigned w, int unsigned h);
    alloc_result_t r;
    int unsigned req, cl, ci, sl, si, edge_px;
    qtba_pkg::node_st_t st;
    r = '{qtba_pkg::STAT_OK, 0, 0, 0, 0, 0, 0, 0};
    req = (w > h) ? w : h;
    if (req > space_edge) begin
      r.status = qtba_pkg::STAT_TOO_LARGE;
      return r;
    end
    cl = cur_l;
    ci = cur_i;
    sl = cl;
    si = ci;
    for (int g = 0; g < 4 * NODES + 8; g++) begin
      st = node_rd(cl, ci);
      edge_px = space_edge >> cl;
      if (st == qtba_pkg::ST_FREE && req <= edge_px && (req > edge_px / 2 || cl == LV)) begin
        if (cl == 0) r.opened = 1;
        node_wr(cl, ci, qtba_pkg::ST_TAKEN);
        cur_l = cl;
        cur_i = ci;
        place_block(r, cl, ci);
        live_lvl.insert(live_lvl.size(), cl);
        live_idx.insert(live_idx.size(), ci);
        return r;
      end
      if (st == qtba_pkg::ST_FREE && req <= edge_px / 2 && cl < LV) begin
        if (cl == 0) r.opened = 1;
        node_wr(cl, ci, qtba_pkg::ST_SPLIT);
        for (int k = 0; k < 4; k++) node_wr(cl + 1, (ci << 2) + k, qtba_pkg::ST_FREE);
        if (sl == cl && si == ci) begin
          sl = cl + 1;
          si = ci << 2;
        end
        cl++;
        ci = ci << 2;
        continue;
      end
      step_leaf(cl, ci);
      if (cl == sl && ci == si) break;
    end
    cur_l = cl;
    cur_i = ci;
    r.status = qtba_pkg::STAT_NO_SPACE;
    r.opened = 0;
    return r;
  endfunction

  function alloc_result_t free_block(int unsigned sz, int unsigned idx);
    alloc_result_t r;
    int unsigned lf, p;
    bit found, all_free;
    r = '{qtba_pkg::STAT_OK, 0, 0, 0, 0, 0, 0, 0};
    found = 0;
    lf = 0;
    for (int l = 0; l <= LV; l++) begin
      if ((space_edge >> l) == sz && node_rd(l, idx) == qtba_pkg::ST_TAKEN) begin
        lf = l;
        found = 1;
        break;
      end
    end
    if (!found) begin
      r.status = qtba_pkg::STAT_BAD_HANDLE;
      return r;
    end
    foreach (live_idx[k]) begin
      if (live_lvl[k] == lf && live_idx[k] == idx) begin
        live_lvl.delete(k);
        live_idx.delete(k);
        break;
      end
    end
    node_wr(lf, idx, qtba_pkg::ST_FREE);
    // Four free siblings collapse into their parent, level by level.
    while (lf > 0) begin
      p = idx >> 2;
      all_free = 1;
      for (int k = 0; k < 4; k++)
        if (node_rd(lf, (p << 2) + k) != qtba_pkg::ST_FREE) all_free = 0;
      if (!all_free) break;
      for (int k = 0; k < 4; k++) node_wr(lf, (p << 2) + k, qtba_pkg::ST_UNUSED);
      node_wr(lf - 1, p, qtba_pkg::ST_FREE);
      if (cur_l == lf && (cur_i >> 2) == p) begin
        cur_l = lf - 1;
        cur_i = p;
      end
      lf--;
      idx = p;
    end
    place_block(r, lf, idx);
    r.released = (lf == 0);
    return r;
  endfunction

  function void note_input(logic kind, logic [11:0] w, logic [11:0] h,
                           logic [11:0] fsz, logic [14:0] fidx);
    alloc_result_t r;
    if (kind == qtba_pkg::KIND_ALLOC) r = alloc_block(w, h);
    else r = free_block(fsz, fidx);
    case (r.status)
      qtba_pkg::STAT_OK: n_ok++;
      qtba_pkg::STAT_TOO_LARGE: n_large++;
      qtba_pkg::STAT_NO_SPACE: n_full++;
      default: n_bad++;
    endcase
    n_opened += r.opened;
    n_released += r.released;
    pending_q.insert(pending_q.size(), r);
  endfunction

  function void report(string what, string expd, string got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %0s: expected %0s, got %0s", what, expd, got);
  endfunction

  function void check_result(logic [55:0] d);
    alloc_result_t e, a;
    a.status = qtba_pkg::status_t'(d[1:0]);
    a.blk_size = d[13:2];
    a.blk_index = d[28:14];
    a.space = d[31:29];
    a.place_x = d[42:32];
    a.place_y = d[53:43];
    a.opened = d[54];
    a.released = d[55];
    if (pending_q.size() == 0) begin
      report("result with nothing pending", "none", $sformatf("%h", d));
      return;
    end
    e = pending_q.pop_front();
    checked++;
    if (a.status !== e.status || a.blk_size !== e.blk_size || a.blk_index !== e.blk_index
        || a.space !== e.space || a.place_x !== e.place_x || a.place_y !== e.place_y
        || a.opened !== e.opened || a.released !== e.released)
      report($sformatf("result %0d", checked),
             $sformatf("st=%0d sz=%0d ix=%0d sp=%0d x=%0d y=%0d o=%0d r=%0d", e.status,
                       e.blk_size, e.blk_index, e.space, e.place_x, e.place_y,
                       e.opened, e.released),
             $sformatf("st=%0d sz=%0d ix=%0d sp=%0d x=%0d y=%0d o=%0d r=%0d", a.status,
                       a.blk_size, a.blk_index, a.space, a.place_x, a.place_y,
                       a.opened, a.released));
  endfunction
endclass

module tb_quadtree_buddy_allocator;
  import qtba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 30000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid, in_tready;
  logic [55:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [55:0] out_tdata;

  alloc_scoreboard sb;
  int unsigned cycles;
  bit no_gaps;
  bit hold_results;
  int unsigned edge_now;

  quadtree_buddy_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("FAIL quadtree_buddy_allocator");
      $finish;
    end
  end

  // Every accepted result beat goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Result side: random stalls per beat unless no_gaps is set, plus one long hold-off on request.
  initial begin
    int n;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_results) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_results = 0;
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      n = no_gaps ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  // Sends one beat after a random gap, none when no_gaps is set, and records it once accepted.
  task automatic send_item(logic kind, int unsigned w, int unsigned h,
                           int unsigned fsz, int unsigned fidx);
    int n;
    logic [55:0] d;
    n = no_gaps ? 0 : $urandom_range(0, 15);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    d = '0;
    d[11:0] = 12'(w);
    d[23:12] = 12'(h);
    d[35:24] = 12'(fsz);
    d[50:36] = 15'(fidx);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= kind;
    do @(posedge clk); while (!in_tready);
    sb.note_input(kind, d[11:0], d[23:12], d[35:24], d[50:36]);
  endtask

  task automatic alloc_item(int unsigned w, int unsigned h);
    send_item(KIND_ALLOC, w, h, $urandom_range(0, 4095), $urandom_range(0, 32767));
  endtask

  // Frees a live handle picked by position in the live list.
  task automatic free_live(int k);
    send_item(KIND_FREE, $urandom_range(0, 4095), $urandom_range(0, 4095),
              (edge_now >> sb.live_lvl[k]) & 12'hFFF, sb.live_idx[k]);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write with setup and access cycles, then read back.
  task automatic cfg_write(logic [2:0] addr, int unsigned v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == {2'b00, REG_SPACE_SIZE}) begin
      sb.set_space_size(v);
      edge_now = v & 12'hFFF;
    end
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr <= {2'b00, REG_SPACE_SIZE};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[11:0] !== edge_now[11:0])
      sb.report("space_size readback", $sformatf("%0d", edge_now), $sformatf("%0d", cfg_prdata));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random item: frees lean on live handles, allocations span every block size.
  task automatic random_item();
    int unsigned e, r, o, pick;
    pick = $urandom_range(0, 99);
    if (sb.live_idx.size() > 0 && (pick < 40 || (sb.live_idx.size() > 24 && pick < 85))) begin
      free_live($urandom_range(0, sb.live_idx.size() - 1));
    end else if (pick > 94) begin
      send_item(KIND_FREE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                            : (edge_now >> $urandom_range(0, 7)),
                $urandom_range(0, 32767) >> $urandom_range(0, 14));
    end else if (pick > 90) begin
      alloc_item($urandom_range(0, 4095), $urandom_range(0, 4095));
    end else begin
      e = edge_now >> $urandom_range(0, 6);
      r = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(e / 2, e);
      o = $urandom_range(0, r);
      if ($urandom_range(0, 1)) alloc_item(r, o);
      else alloc_item(o, r);
    end
  endtask

  initial begin
    int unsigned edges[8];
    edges = '{2048, 32, 256, 2048, 64, 1024, 128, 512};
    sb = new();
    cycles = 0;
    no_gaps = 0;
    hold_results = 0;
    edge_now = SPACE_SIZE_RST;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_ALLOC;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero request, deepest leaf, too large, odd shapes, bad handles.
    alloc_item(0, 0);
    alloc_item(1, 1);
    alloc_item(4095, 0);
    alloc_item(0, 2049);
    alloc_item(2048, 2048);
    alloc_item(1024, 3);
    alloc_item(33, 600);
    send_item(KIND_FREE, 0, 0, 0, 0);
    send_item(KIND_FREE, 4095, 4095, 2048, 32767);
    send_item(KIND_FREE, 0, 0, 4095, 7);
    // Fill every space, so the walk wraps the whole ring without a fit.
    repeat (8) alloc_item(2048, 1);
    alloc_item(1, 2048);
    while (sb.live_idx.size() > 0) free_live(0);

    // Phases at several space sizes; tree and cursor carry across each write.
    foreach (edges[p]) begin
      wait_idle();
      if (p == 3) cfg_write(3'd4, 77);
      cfg_write({2'b00, REG_SPACE_SIZE}, edges[p]);
      no_gaps = (p == 1 || p == 5);
      for (int k = 0; k < 215; k++) begin
        if (p == 2 && k == 50) hold_results = 1;
        if (p == 4 && k == 100) begin
          in_tvalid <= 1'b0;
          while (sb.pending_q.size() != 0) @(posedge clk);
        end
        random_item();
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Checked %0d results: %0d ok, %0d too large, %0d no space, %0d bad handle.",
             sb.checked, sb.n_ok, sb.n_large, sb.n_full, sb.n_bad);
    $display("Spaces opened %0d times and released %0d times across eight size phases.",
             sb.n_opened, sb.n_released);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("PASS quadtree_buddy_allocator");
    end else begin
      $display("FAIL quadtree_buddy_allocator");
    end
    $finish;
  end
endmodule

`default_nettype wire
